/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLY(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* sv/rlwt_pkg.sv */
package rlwt_pkg;

    localparam int REQ_TYPE_W  = 2;
    localparam int REQUESTER_W = 2;
    localparam int RESOURCE_W  = 1;
    localparam int TIMEOUT_W   = 8;

    localparam logic [REQ_TYPE_W-1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_TICK    = 2'd2;

    localparam logic OUTCOME_GRANT   = 1'b0;
    localparam logic OUTCOME_TIMEOUT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic exec_emits;
        logic scan_hit;
        logic scan_last;
    } dp_status_t;

endpackage

/* sv/rlwt_in_if.sv */
interface rlwt_in_if import rlwt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REQ_TYPE_W-1:0]  req_type;
    logic [REQUESTER_W-1:0] requester;
    logic [RESOURCE_W-1:0]  resource;
    logic [TIMEOUT_W-1:0]   timeout_ticks;

    modport source (
        output valid, req_type, requester, resource, timeout_ticks,
        input  ready
    );

    modport sink (
        input  valid, req_type, requester, resource, timeout_ticks,
        output ready
    );
endinterface

/* sv/rlwt_out_if.sv */
interface rlwt_out_if import rlwt_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [REQUESTER_W-1:0] target;
    logic [RESOURCE_W-1:0]  target_resource;
    logic                   outcome;
    logic                   last;

    modport source (
        output valid, target, target_resource, outcome, last,
        input  ready
    );

    modport sink (
        input  valid, target, target_resource, outcome, last,
        output ready
    );
endinterface

/* sv/resource_lock_with_timeout.sv */
// Lock manager with timeout. Requesters acquire and release named resources; a busy
// resource makes the requester wait up to timeout_ticks ticks, and release hands the
// resource to the lowest-numbered waiter. Each result names the woken requester, the
// resource and the outcome (grant or timeout); last marks the final result of a
// transaction. One transaction is worked at a time: an acquire or release is accepted,
// then executed against the lock state; a tick is accepted, then the expiry scan
// visits one requester per cycle (an expiring requester waits for room in the output
// register) and can emit one timeout per cycle. A full output register that is not
// drained stalls the execute or scan step. A new transaction is accepted only once the
// previous one is done: after its execute step, or after the scan has visited the last requester.
`include "assert_macros.svh"

module resource_lock_with_timeout import rlwt_pkg::*; #(
    parameter int NUM_REQUESTERS = 4,
    parameter int NUM_RESOURCES  = 2,
    parameter int TIMEOUT_BITS   = 8
) (
    input logic        clk,
    input logic        rst_n,
    rlwt_in_if.sink    request,
    rlwt_out_if.source result
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    rlwt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_type  (request.req_type),
        .status   (dp_status),
        .in_ready (request.ready),
        .cmd      (dp_cmd)
    );

    rlwt_dp #(
        .NUM_REQUESTERS (NUM_REQUESTERS),
        .NUM_RESOURCES  (NUM_RESOURCES),
        .TIMEOUT_BITS   (TIMEOUT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_req_type      (request.req_type),
        .in_requester     (request.requester),
        .in_resource      (request.resource),
        .in_timeout_ticks (request.timeout_ticks),
        .cmd              (dp_cmd),
        .status           (dp_status),
        .out_ch           (result)
    );

    // a result is only produced when the output register can take it
    `ASSERT_IMPLY(a_exec_room, clk, rst_n, dp_cmd.exec && dp_status.exec_emits, dp_status.out_free)
    `ASSERT_IMPLY(a_scan_room, clk, rst_n, dp_cmd.step && dp_status.scan_hit, dp_status.out_free)
    // no new transaction while one is being worked
    `ASSERT_IMPLY(a_busy_no_accept, clk, rst_n, request.ready, !(dp_cmd.exec || dp_cmd.step))
    // acquire/release executes right after accept unless the output is blocked
    `ASSERT_NEXT(a_exec_follows, clk, rst_n, dp_cmd.load && (request.req_type != REQ_TICK), dp_cmd.exec || !dp_status.out_free)

endmodule

/* sv/rlwt_ctrl.sv */
module rlwt_ctrl import rlwt_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [REQ_TYPE_W-1:0] in_type,
    input  dp_status_t            status,
    output logic                  in_ready,
    output dp_cmd_t               cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (in_type == REQ_TICK) ? ST_SCAN : ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold while a result is due and the output register is full
                if (!status.exec_emits || status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!status.scan_hit || status.out_free)
                begin
                    cmd.step = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/rlwt_dp.sv */
module rlwt_dp import rlwt_pkg::*; #(
    parameter int NUM_REQUESTERS = 4,
    parameter int NUM_RESOURCES  = 2,
    parameter int TIMEOUT_BITS   = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [REQ_TYPE_W-1:0]  in_req_type,
    input  logic [REQUESTER_W-1:0] in_requester,
    input  logic [RESOURCE_W-1:0]  in_resource,
    input  logic [TIMEOUT_W-1:0]   in_timeout_ticks,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    rlwt_out_if.source             out_ch
);

    localparam int RQ_IW    = (NUM_REQUESTERS > 1) ? $clog2(NUM_REQUESTERS) : 1;
    localparam int RS_IW    = (NUM_RESOURCES > 1) ? $clog2(NUM_RESOURCES) : 1;
    localparam int RQ_CMP_W = ((RQ_IW > REQUESTER_W) ? RQ_IW : REQUESTER_W) + 1;
    localparam int RS_CMP_W = ((RS_IW > RESOURCE_W) ? RS_IW : RESOURCE_W) + 1;
    localparam int CD_CMP_W = (TIMEOUT_BITS > TIMEOUT_W) ? TIMEOUT_BITS : TIMEOUT_W;

    // latched transaction
    logic [REQ_TYPE_W-1:0]  item_type_reg, item_type_next;
    logic [REQUESTER_W-1:0] item_rq_reg, item_rq_next;
    logic [RESOURCE_W-1:0]  item_rs_reg, item_rs_next;
    logic [TIMEOUT_W-1:0]   item_to_reg, item_to_next;

    // lock state
    logic [NUM_RESOURCES-1:0]  holder_valid_reg, holder_valid_next;
    logic [RQ_IW-1:0]          holder_reg [NUM_RESOURCES];
    logic [RQ_IW-1:0]          holder_next [NUM_RESOURCES];
    logic [NUM_REQUESTERS-1:0] awaited_valid_reg, awaited_valid_next;
    logic [RS_IW-1:0]          awaited_res_reg [NUM_REQUESTERS];
    logic [RS_IW-1:0]          awaited_res_next [NUM_REQUESTERS];
    logic [TIMEOUT_BITS-1:0]   countdown_reg [NUM_REQUESTERS];
    logic [TIMEOUT_BITS-1:0]   countdown_next [NUM_REQUESTERS];

    // tick scan
    logic [NUM_REQUESTERS-1:0] tmo_mask_reg, tmo_mask_next;
    logic [RQ_IW-1:0]          scan_idx_reg, scan_idx_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [REQUESTER_W-1:0] out_target_reg, out_target_next;
    logic [RESOURCE_W-1:0]  out_res_reg, out_res_next;
    logic                   out_outcome_reg, out_outcome_next;
    logic                   out_last_reg, out_last_next;

    logic [RQ_IW-1:0]          rq_idx;
    logic [RS_IW-1:0]          rs_idx;
    logic                      item_ok;
    logic                      is_acq;
    logic                      can_grant;
    logic                      to_zero;
    logic [CD_CMP_W-1:0]       to_ext;
    logic [TIMEOUT_BITS-1:0]   cd_load;
    logic [NUM_REQUESTERS-1:0] wmask;
    logic [RQ_IW-1:0]          win;
    logic                      win_found;
    logic                      exec_emits;
    logic                      out_free;
    logic                      scan_hit;
    logic                      scan_last;
    logic [NUM_REQUESTERS-1:0] mask_rest;
    logic                      emit_exec;
    logic                      emit_scan;

    assign rq_idx  = RQ_IW'(item_rq_reg);
    assign rs_idx  = RS_IW'(item_rs_reg);
    assign is_acq  = (item_type_reg == REQ_ACQUIRE);
    assign item_ok = ((item_type_reg == REQ_ACQUIRE) || (item_type_reg == REQ_RELEASE))
                     && (RQ_CMP_W'(item_rq_reg) < RQ_CMP_W'(NUM_REQUESTERS))
                     && (RS_CMP_W'(item_rs_reg) < RS_CMP_W'(NUM_RESOURCES));

    assign can_grant = !holder_valid_reg[rs_idx] || (holder_reg[rs_idx] == rq_idx);
    assign to_zero   = (item_to_reg == '0);
    assign to_ext    = CD_CMP_W'(item_to_reg);
    assign cd_load   = (to_ext > CD_CMP_W'({TIMEOUT_BITS{1'b1}})) ? {TIMEOUT_BITS{1'b1}}
                                                                  : TIMEOUT_BITS'(to_ext);

    // waiters on the released resource, the releaser itself excluded
    always_comb
    begin
        win = '0;
        for (int i = 0; i < NUM_REQUESTERS; i++)
        begin
            wmask[i] = awaited_valid_reg[i] && (awaited_res_reg[i] == rs_idx)
                       && (RQ_IW'(i) != rq_idx);
        end
        for (int i = NUM_REQUESTERS - 1; i >= 0; i--)
        begin
            if (wmask[i])
            begin
                win = RQ_IW'(i);
            end
        end
    end

    assign win_found  = |wmask;
    assign exec_emits = item_ok && (is_acq ? (can_grant || to_zero) : win_found);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign scan_hit   = tmo_mask_reg[scan_idx_reg];
    assign scan_last  = (scan_idx_reg == RQ_IW'(NUM_REQUESTERS - 1));
    assign mask_rest  = (tmo_mask_reg >> scan_idx_reg) >> 1;
    assign emit_exec  = cmd.exec && exec_emits;
    assign emit_scan  = cmd.step && scan_hit;

    assign status.out_free   = out_free;
    assign status.exec_emits = exec_emits;
    assign status.scan_hit   = scan_hit;
    assign status.scan_last  = scan_last;

    always_comb
    begin
        item_type_next     = item_type_reg;
        item_rq_next       = item_rq_reg;
        item_rs_next       = item_rs_reg;
        item_to_next       = item_to_reg;
        holder_valid_next  = holder_valid_reg;
        holder_next        = holder_reg;
        awaited_valid_next = awaited_valid_reg;
        awaited_res_next   = awaited_res_reg;
        countdown_next     = countdown_reg;
        tmo_mask_next      = tmo_mask_reg;
        scan_idx_next      = scan_idx_reg;
        out_valid_next     = out_valid_reg;
        out_target_next    = out_target_reg;
        out_res_next       = out_res_reg;
        out_outcome_next   = out_outcome_reg;
        out_last_next      = out_last_reg;

        if (cmd.load)
        begin
            item_type_next = in_req_type;
            item_rq_next   = in_requester;
            item_rs_next   = in_resource;
            item_to_next   = in_timeout_ticks;
            if (in_req_type == REQ_TICK)
            begin
                // all countdowns move at once; expiries are drained by the scan
                for (int i = 0; i < NUM_REQUESTERS; i++)
                begin
                    tmo_mask_next[i] = (countdown_reg[i] == '0) && awaited_valid_reg[i];
                    if (countdown_reg[i] != '0)
                    begin
                        countdown_next[i] = countdown_reg[i] - TIMEOUT_BITS'(1);
                    end
                end
                scan_idx_next = '0;
            end
        end

        if (cmd.exec && item_ok)
        begin
            awaited_valid_next[rq_idx] = 1'b0;
            if (is_acq)
            begin
                if (can_grant)
                begin
                    holder_valid_next[rs_idx] = 1'b1;
                    holder_next[rs_idx]       = rq_idx;
                    countdown_next[rq_idx]    = '0;
                end
                else if (to_zero)
                begin
                    countdown_next[rq_idx] = '0;
                end
                else
                begin
                    countdown_next[rq_idx]     = cd_load;
                    awaited_valid_next[rq_idx] = 1'b1;
                    awaited_res_next[rq_idx]   = rs_idx;
                end
            end
            else
            begin
                holder_valid_next[rs_idx] = 1'b0;
                if (win_found)
                begin
                    holder_valid_next[rs_idx] = 1'b1;
                    holder_next[rs_idx]       = win;
                    awaited_valid_next[win]   = 1'b0;
                    countdown_next[win]       = '0;
                end
            end
        end

        if (cmd.step)
        begin
            if (scan_hit)
            begin
                awaited_valid_next[scan_idx_reg] = 1'b0;
            end
            scan_idx_next = scan_idx_reg + RQ_IW'(1);
        end

        if (emit_exec)
        begin
            out_valid_next   = 1'b1;
            out_target_next  = is_acq ? item_rq_reg : REQUESTER_W'(win);
            out_res_next     = item_rs_reg;
            out_outcome_next = (is_acq && !can_grant) ? OUTCOME_TIMEOUT : OUTCOME_GRANT;
            out_last_next    = 1'b1;
        end
        else if (emit_scan)
        begin
            out_valid_next   = 1'b1;
            out_target_next  = REQUESTER_W'(scan_idx_reg);
            out_res_next     = RESOURCE_W'(awaited_res_reg[scan_idx_reg]);
            out_outcome_next = OUTCOME_TIMEOUT;
            out_last_next    = (mask_rest == '0);
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holder_valid_reg  <= '0;
            awaited_valid_reg <= '0;
            countdown_reg     <= '{default: '0};
            tmo_mask_reg      <= '0;
            scan_idx_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            holder_valid_reg  <= holder_valid_next;
            awaited_valid_reg <= awaited_valid_next;
            countdown_reg     <= countdown_next;
            tmo_mask_reg      <= tmo_mask_next;
            scan_idx_reg      <= scan_idx_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_type_reg   <= item_type_next;
        item_rq_reg     <= item_rq_next;
        item_rs_reg     <= item_rs_next;
        item_to_reg     <= item_to_next;
        holder_reg      <= holder_next;
        awaited_res_reg <= awaited_res_next;
        out_target_reg  <= out_target_next;
        out_res_reg     <= out_res_next;
        out_outcome_reg <= out_outcome_next;
        out_last_reg    <= out_last_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.target          = out_target_reg;
    assign out_ch.target_resource = out_res_reg;
    assign out_ch.outcome         = out_outcome_reg;
    assign out_ch.last            = out_last_reg;

endmodule

/* tb/resource_lock_with_timeout_checker.sv */
module resource_lock_with_timeout_checker import rlwt_pkg::*; #(
    parameter int NUM_REQUESTERS = 4,
    parameter int NUM_RESOURCES  = 2
) (
    input  logic clk,
    input  logic rst_n,
    rlwt_in_if   request,
    rlwt_out_if  result,
    output int   fail_count,
    output int   open_wakeups,
    output int   grants_seen,
    output int   timeouts_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [REQUESTER_W-1:0] target;
        logic [RESOURCE_W-1:0]  res;
        logic                   outcome;
        logic                   last;
    } wakeup_t;

    // lock table and wait list as the block should hold them
    logic                   lock_held   [NUM_RESOURCES];
    logic [REQUESTER_W-1:0] lock_owner  [NUM_RESOURCES];
    int unsigned            waiters_on  [NUM_RESOURCES];
    logic                   is_waiting  [NUM_REQUESTERS];
    logic [RESOURCE_W-1:0]  wanted_lock [NUM_REQUESTERS];
    logic [TIMEOUT_W-1:0]   ticks_left  [NUM_REQUESTERS];

    wakeup_t wakeups_due[$];

    function automatic void drop_wait(input int idx);
        if (is_waiting[idx])
        begin
            if (waiters_on[wanted_lock[idx]] > 0)
                waiters_on[wanted_lock[idx]]--;
            is_waiting[idx]  = 1'b0;
            wanted_lock[idx] = '0;
        end
    endfunction

    function automatic void predict_wakeups(
        input logic [REQ_TYPE_W-1:0]  kind,
        input logic [REQUESTER_W-1:0] who,
        input logic [RESOURCE_W-1:0]  res,
        input logic [TIMEOUT_W-1:0]   ticks
    );
        wakeup_t               batch[$];
        logic [RESOURCE_W-1:0] lost;
        case (kind)
            REQ_TICK:
            begin
                for (int i = 0; i < NUM_REQUESTERS; i++)
                begin
                    if (ticks_left[i] != 0)
                        ticks_left[i]--;
                    else if (is_waiting[i])
                    begin
                        lost = wanted_lock[i];
                        drop_wait(i);
                        batch.push_back('{REQUESTER_W'(i), lost, OUTCOME_TIMEOUT, 1'b0});
                    end
                end
            end
            REQ_ACQUIRE:
            begin
                // a repeated request first drops the old wait
                drop_wait(who);
                if (!lock_held[res] || lock_owner[res] == who)
                begin
                    lock_held[res]  = 1'b1;
                    lock_owner[res] = who;
                    ticks_left[who] = '0;
                    batch.push_back('{who, res, OUTCOME_GRANT, 1'b0});
                end
                else if (ticks == 0)
                begin
                    ticks_left[who] = '0;
                    batch.push_back('{who, res, OUTCOME_TIMEOUT, 1'b0});
                end
                else
                begin
                    ticks_left[who]  = ticks;
                    is_waiting[who]  = 1'b1;
                    wanted_lock[who] = res;
                    waiters_on[res]++;
                end
            end
            REQ_RELEASE:
            begin
                // frees the lock whoever releases it
                lock_held[res]  = 1'b0;
                lock_owner[res] = '0;
                drop_wait(who);
                if (waiters_on[res] > 0)
                begin
                    for (int i = 0; i < NUM_REQUESTERS; i++)
                    begin
                        if (is_waiting[i] && wanted_lock[i] == res)
                        begin
                            drop_wait(i);
                            lock_held[res]  = 1'b1;
                            lock_owner[res] = REQUESTER_W'(i);
                            ticks_left[i]   = '0;
                            batch.push_back('{REQUESTER_W'(i), res, OUTCOME_GRANT, 1'b0});
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size()-1].last = 1'b1;
        foreach (batch[k])
            wakeups_due.push_back(batch[k]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        wakeup_t seen;
        wakeup_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_RESOURCES; i++)
            begin
                lock_held[i]  = 1'b0;
                lock_owner[i] = '0;
                waiters_on[i] = 0;
            end
            for (int i = 0; i < NUM_REQUESTERS; i++)
            begin
                is_waiting[i]  = 1'b0;
                wanted_lock[i] = '0;
                ticks_left[i]  = '0;
            end
            wakeups_due.delete();
            fail_count    = 0;
            open_wakeups  = 0;
            grants_seen   = 0;
            timeouts_seen = 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                seen = '{result.target, result.target_resource, result.outcome, result.last};
                if (wakeups_due.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result target=%0d res=%0d outcome=%0d last=%0d",
                             $time, seen.target, seen.res, seen.outcome, seen.last);
                end
                else
                begin
                    want = wakeups_due.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        $display("%0t: result mismatch, expected target=%0d res=%0d outcome=%0d last=%0d,",
                                 $time, want.target, want.res, want.outcome, want.last,
                                 " actual target=%0d res=%0d outcome=%0d last=%0d",
                                 seen.target, seen.res, seen.outcome, seen.last);
                    end
                end
                if (seen.outcome == OUTCOME_GRANT)
                    grants_seen++;
                else
                    timeouts_seen++;
            end
            if (request.valid && request.ready)
                predict_wakeups(request.req_type, request.requester, request.resource,
                                request.timeout_ticks);
            open_wakeups = wakeups_due.size();
        end
    end

endmodule

/* tb/resource_lock_with_timeout_tb.sv */
module resource_lock_with_timeout_tb import rlwt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 125;
    localparam int SETTLE_CYCLES = 12;

    logic clk = 1'b0;
    logic rst_n;

    rlwt_in_if  request ();
    rlwt_out_if result ();

    int fail_count;
    int open_wakeups;
    int grants_seen;
    int timeouts_seen;

    int burst_left;
    int n_acquire;
    int n_release;
    int n_tick;
    int n_unused;

    int stall_mode;
    int stall_stretch;

    resource_lock_with_timeout dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request),
        .result (result)
    );

    resource_lock_with_timeout_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .result       (result),
        .fail_count   (fail_count),
        .open_wakeups (open_wakeups),
        .grants_seen  (grants_seen),
        .timeouts_seen(timeouts_seen)
    );

    always #5 clk = ~clk;

    // receiver: switches between always ready, coin flip and mostly stalled
    always @(posedge clk)
    begin
        if (stall_stretch == 0)
        begin
            stall_mode    <= $urandom_range(0, 2);
            stall_stretch <= $urandom_range(10, 60);
        end
        else
            stall_stretch <= stall_stretch - 1;
        case (stall_mode)
            0:       result.ready <= 1'b1;
            1:       result.ready <= 1'($urandom_range(0, 1));
            default: result.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    task automatic send_transaction(
        input logic [REQ_TYPE_W-1:0]  kind,
        input logic [REQUESTER_W-1:0] who,
        input logic [RESOURCE_W-1:0]  res,
        input logic [TIMEOUT_W-1:0]   ticks
    );
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                request.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        request.valid         <= 1'b1;
        request.req_type      <= kind;
        request.requester     <= who;
        request.resource      <= res;
        request.timeout_ticks <= ticks;
        do
            @(posedge clk);
        while (!request.ready);
        burst_left--;
        case (kind)
            REQ_ACQUIRE: n_acquire++;
            REQ_RELEASE: n_release++;
            REQ_TICK:    n_tick++;
            default:     n_unused++;
        endcase
    endtask

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int                     pick;
        int                     sel;
        int                     counted;
        logic [REQ_TYPE_W-1:0]  kind;
        logic [TIMEOUT_W-1:0]   ticks;

        rst_n                 <= 1'b0;
        request.valid         <= 1'b0;
        request.req_type      <= REQ_ACQUIRE;
        request.requester     <= '0;
        request.resource      <= '0;
        request.timeout_ticks <= '0;
        burst_left    = 0;
        n_acquire     = 0;
        n_release     = 0;
        n_tick        = 0;
        n_unused      = 0;
        counted       = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: grant, holder re-request, refusal, waits, hand-over
        send_transaction(REQ_ACQUIRE, 2'd0, 1'b0, 8'd0);
        send_transaction(REQ_ACQUIRE, 2'd0, 1'b0, 8'd5);
        send_transaction(REQ_ACQUIRE, 2'd1, 1'b1, 8'd255);
        send_transaction(REQ_ACQUIRE, 2'd2, 1'b0, 8'd0);
        send_transaction(REQ_ACQUIRE, 2'd3, 1'b0, 8'd255);
        send_transaction(REQ_ACQUIRE, 2'd2, 1'b0, 8'd3);
        send_transaction(REQ_ACQUIRE, 2'd3, 1'b0, 8'd2);
        send_transaction(REQ_RELEASE, 2'd0, 1'b0, 8'd0);
        send_transaction(REQ_TICK,    2'd3, 1'b1, 8'd255);
        // waiting releaser drops its wait; lock released by a non-holder
        send_transaction(REQ_RELEASE, 2'd3, 1'b1, 8'd0);
        send_transaction(REQ_RELEASE, 2'd3, 1'b1, 8'd0);
        send_transaction(REQ_UNUSED,  2'd1, 1'b1, 8'd170);
        // four waiters that all time out on the same tick
        send_transaction(REQ_ACQUIRE, 2'd0, 1'b1, 8'd0);
        send_transaction(REQ_ACQUIRE, 2'd1, 1'b0, 8'd1);
        send_transaction(REQ_ACQUIRE, 2'd3, 1'b1, 8'd1);
        send_transaction(REQ_ACQUIRE, 2'd2, 1'b1, 8'd1);
        send_transaction(REQ_ACQUIRE, 2'd0, 1'b0, 8'd1);
        send_transaction(REQ_TICK,    2'd0, 1'b0, 8'd0);
        send_transaction(REQ_TICK,    2'd0, 1'b0, 8'd0);
        send_transaction(REQ_RELEASE, 2'd2, 1'b0, 8'd0);
        send_transaction(REQ_RELEASE, 2'd0, 1'b1, 8'd0);

        // random mix, short timeouts so ticks keep expiring waiters
        while (counted < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                kind = REQ_ACQUIRE;
            else if (pick < 70)
                kind = REQ_RELEASE;
            else if (pick < 95)
                kind = REQ_TICK;
            else
                kind = REQ_UNUSED;
            sel = $urandom_range(0, 9);
            if (sel == 0)
                ticks = '0;
            else if (sel == 1)
                ticks = TIMEOUT_W'($urandom_range(0, 255));
            else
                ticks = TIMEOUT_W'($urandom_range(1, 5));
            send_transaction(kind, REQUESTER_W'($urandom_range(0, 3)),
                             RESOURCE_W'($urandom_range(0, 1)), ticks);
            if (kind != REQ_UNUSED)
                counted++;
        end
        request.valid <= 1'b0;

        @(posedge clk);
        while (open_wakeups != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d acquires, %0d releases, %0d ticks, %0d unused-type transactions",
                 n_acquire, n_release, n_tick, n_unused);
        $display("Checked %0d grants and %0d timeouts/refusals",
                 grants_seen, timeouts_seen);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
